### rtl/mlv_pkg.sv
// ----------------------------------------------------------------------------
// mlv_pkg
// Shared types and constants for the maglev table build and lookup block.
// ----------------------------------------------------------------------------
package mlv_pkg;

   localparam int TABLE_DEPTH_DEF  = 4096;
   localparam int MAX_BACKENDS_DEF = 64;
   localparam int MOD_STEPS        = 32;

   localparam logic [12:0] TABLE_SIZE_RST    = 13'd4093;
   localparam logic [15:0] MERGE_TIMEOUT_RST = 16'd10;

   localparam logic CSR_TABLE_SIZE    = 1'b0;
   localparam logic CSR_MERGE_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD   = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_TICK   = 2'd2,
      REQ_CLEAR  = 2'd3
   } mlv_req_kind_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] backend_hash_a;
      logic [31:0] backend_hash_b;
      logic        last_backend;
      logic [31:0] key_hash;
   } mlv_req_type;

   typedef struct packed {
      logic       stable;
      logic       curr_valid;
      logic [5:0] curr_backend;
      logic       prev_valid;
      logic [5:0] prev_backend;
      logic       merged;
      logic       overflow;
   } mlv_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LD_A,
      ST_LD_B,
      ST_LD_WR,
      ST_LK_MOD,
      ST_LK_DATA,
      ST_CP_SWEEP,
      ST_B_START,
      ST_BP_SWEEP,
      ST_BC_SWEEP,
      ST_PR_START,
      ST_PR_RD,
      ST_PR_LAT,
      ST_PR_GOP,
      ST_PR_MP,
      ST_PR_MS,
      ST_PR_WR,
      ST_RUN_INIT,
      ST_TURN_RD,
      ST_TURN_LAT,
      ST_PROBE,
      ST_CHECK,
      ST_TURN_WR,
      ST_FINISH,
      ST_RESP
   } mlv_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_LD_OVF,
      OP_LD_OFF,
      OP_LD_SKIP,
      OP_LD_WRITE,
      OP_LK_READ,
      OP_LK_CAPT,
      OP_TICK,
      OP_CLEAR,
      OP_COPY_STEP,
      OP_CLR_STEP,
      OP_BI_ZERO,
      OP_BK_LATCH,
      OP_PR_POS,
      OP_PR_SKIP,
      OP_PR_WRITE,
      OP_RUN_INIT,
      OP_PROBE,
      OP_CLAIM,
      OP_TURN_WRITE,
      OP_FINISH,
      OP_RESP
   } mlv_op_type;

   typedef enum logic [2:0] {
      MS_HASH_A,
      MS_HASH_B,
      MS_KEY,
      MS_POS,
      MS_SKIP
   } mlv_msrc_type;

   typedef struct packed {
      mlv_op_type   op;
      logic         mod_go;
      mlv_msrc_type mod_src;
   } mlv_cmd_type;

   typedef struct packed {
      mlv_req_kind_type req_kind;
      logic             last;
      logic             live;
      logic             pending;
      logic             tick_merge;
      logic             ovf_full;
      logic             mod_done;
      logic             sweep_last;
      logic             n_zero;
      logic             last_bi;
      logic             full;
      logic             exhausted;
      logic             taken_hit;
      logic             claimed;
      logic             rsp_free;
   } mlv_status_type;

endpackage

### rtl/maglev_table_build_and_lookup.sv
// ----------------------------------------------------------------------------
// maglev_table_build_and_lookup
// Maglev consistent-hash table: backend loads, table build, lookup, merge.
//
// req_* carries one request per beat (load, lookup, tick, clear); rsp_*
// returns exactly one result beat per request, in order. csr_* writes
// table_size (index 0) and merge_timeout (index 1); csr_ready is always high.
// One request is worked at a time; req_stall is low only when the sequencer
// is idle, and the result register lets the next request enter while a
// result still waits on rsp_stall.
// Work per request, paced by the bit-serial remainder unit (one bit a cycle):
//   a lookup reduces its key, a load its offset and skip; clear and plain tick do not.
//   tick that merges: adds a copy sweep, one entry a cycle.
//   load marked last: a copy sweep (unless a merge is pending) and a clear
//   sweep, a re-reduction of each backend's offset and skip, then probes of
//   the slot-taken memory until all slots are filled or a round claims none.
// Reset leaves both tables reading empty, no merge pending, registers at
// table_size 4093 and merge_timeout 10; no clearing pass is needed.
// ----------------------------------------------------------------------------
module maglev_table_build_and_lookup #(
   parameter int TABLE_DEPTH  = mlv_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_BACKENDS = mlv_pkg::MAX_BACKENDS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mlv_pkg::mlv_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mlv_pkg::mlv_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic [15:0]          csr_wdata
);
   import mlv_pkg::*;

   mlv_cmd_type    cmd;
   mlv_status_type status;

   assign csr_ready = 1'b1;

   mlv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mlv_dpath #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_BACKENDS (MAX_BACKENDS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted beat holds off the next one until its work is done
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

   // the remainder unit never finishes right after a start
   a_mod_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_go |=> !status.mod_done)
      else $error("remainder done too early");

   a_stable_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stable && rsp_data.prev_valid) |->
      (rsp_data.curr_valid && rsp_data.prev_backend == rsp_data.curr_backend))
      else $error("stable lookup with differing entries");

endmodule

### rtl/mlv_mod.sv
// ----------------------------------------------------------------------------
// mlv_mod
// Bit-serial remainder unit: 32-bit dividend by a narrow divisor, one bit
// per cycle, done pulses when the remainder is ready and it then holds.
// ----------------------------------------------------------------------------
module mlv_mod #(
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic [31:0]   dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] rem
);
   import mlv_pkg::*;

   localparam int CW = $clog2(MOD_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0]   dvd_ff, dvd_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   shifted;

   assign shifted = {rem_ff, dvd_ff[31]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (go) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = DW'(shifted - {1'b0, div_ff});
         end else begin
            rem_in = shifted[DW-1:0];
         end
         dvd_in = {dvd_ff[30:0], 1'b0};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(MOD_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

### rtl/mlv_ctrl.sv
// ----------------------------------------------------------------------------
// mlv_ctrl
// Sequencer for loads, lookups, ticks, clears and the table build.
// ----------------------------------------------------------------------------
module mlv_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  mlv_pkg::mlv_status_type status,
   output mlv_pkg::mlv_cmd_type    cmd
);
   import mlv_pkg::*;

   mlv_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            unique case (status.req_kind)
               REQ_LOAD: begin
                  if (!status.ovf_full) state_in = ST_LD_A;
                  else if (status.last) state_in = ST_B_START;
                  else state_in = ST_RESP;
               end
               REQ_LOOKUP: state_in = status.live ? ST_LK_MOD : ST_RESP;
               REQ_TICK: begin
                  state_in = (status.pending && status.tick_merge) ? ST_CP_SWEEP : ST_RESP;
               end
               REQ_CLEAR: state_in = ST_RESP;
               default: state_in = ST_RESP;
            endcase
         end
         ST_LD_A: if (status.mod_done) state_in = ST_LD_B;
         ST_LD_B: if (status.mod_done) state_in = ST_LD_WR;
         ST_LD_WR: state_in = status.last ? ST_B_START : ST_RESP;
         ST_LK_MOD: if (status.mod_done) state_in = ST_LK_DATA;
         ST_LK_DATA: state_in = ST_RESP;
         ST_CP_SWEEP: if (status.sweep_last) state_in = ST_RESP;
         ST_B_START: state_in = status.pending ? ST_BC_SWEEP : ST_BP_SWEEP;
         ST_BP_SWEEP: if (status.sweep_last) state_in = ST_BC_SWEEP;
         ST_BC_SWEEP: if (status.sweep_last) state_in = ST_PR_START;
         ST_PR_START: state_in = status.n_zero ? ST_FINISH : ST_PR_RD;
         ST_PR_RD: state_in = ST_PR_LAT;
         ST_PR_LAT: state_in = ST_PR_GOP;
         ST_PR_GOP: state_in = ST_PR_MP;
         ST_PR_MP: if (status.mod_done) state_in = ST_PR_MS;
         ST_PR_MS: if (status.mod_done) state_in = ST_PR_WR;
         ST_PR_WR: state_in = status.last_bi ? ST_RUN_INIT : ST_PR_RD;
         ST_RUN_INIT: state_in = ST_TURN_RD;
         ST_TURN_RD: state_in = status.full ? ST_FINISH : ST_TURN_LAT;
         ST_TURN_LAT: state_in = ST_PROBE;
         ST_PROBE: state_in = status.exhausted ? ST_TURN_WR : ST_CHECK;
         ST_CHECK: state_in = status.taken_hit ? ST_PROBE : ST_TURN_WR;
         ST_TURN_WR: begin
            // a full round with no claim ends the build
            state_in = (status.last_bi && !status.claimed) ? ST_FINISH : ST_TURN_RD;
         end
         ST_FINISH: state_in = ST_RESP;
         ST_RESP: if (status.rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op      = OP_NONE;
      cmd.mod_go  = 1'b0;
      cmd.mod_src = MS_HASH_A;
      unique case (state_ff)
         ST_IDLE: if (req_valid) cmd.op = OP_LATCH;
         ST_DISPATCH: begin
            unique case (status.req_kind)
               REQ_LOAD: begin
                  if (status.ovf_full) begin
                     cmd.op = OP_LD_OVF;
                  end else begin
                     cmd.mod_go  = 1'b1;
                     cmd.mod_src = MS_HASH_A;
                  end
               end
               REQ_LOOKUP: begin
                  cmd.mod_go  = status.live;
                  cmd.mod_src = MS_KEY;
               end
               REQ_TICK: cmd.op = OP_TICK;
               REQ_CLEAR: cmd.op = OP_CLEAR;
               default: cmd.op = OP_NONE;
            endcase
         end
         ST_LD_A: begin
            if (status.mod_done) begin
               cmd.op      = OP_LD_OFF;
               cmd.mod_go  = 1'b1;
               cmd.mod_src = MS_HASH_B;
            end
         end
         ST_LD_B: if (status.mod_done) cmd.op = OP_LD_SKIP;
         ST_LD_WR: cmd.op = OP_LD_WRITE;
         ST_LK_MOD: if (status.mod_done) cmd.op = OP_LK_READ;
         ST_LK_DATA: cmd.op = OP_LK_CAPT;
         ST_CP_SWEEP, ST_BP_SWEEP: cmd.op = OP_COPY_STEP;
         ST_BC_SWEEP: cmd.op = OP_CLR_STEP;
         ST_PR_START: cmd.op = OP_BI_ZERO;
         ST_PR_LAT, ST_TURN_LAT: cmd.op = OP_BK_LATCH;
         ST_PR_GOP: begin
            cmd.mod_go  = 1'b1;
            cmd.mod_src = MS_POS;
         end
         ST_PR_MP: begin
            if (status.mod_done) begin
               cmd.op      = OP_PR_POS;
               cmd.mod_go  = 1'b1;
               cmd.mod_src = MS_SKIP;
            end
         end
         ST_PR_MS: if (status.mod_done) cmd.op = OP_PR_SKIP;
         ST_PR_WR: cmd.op = OP_PR_WRITE;
         ST_RUN_INIT: cmd.op = OP_RUN_INIT;
         ST_PROBE: if (!status.exhausted) cmd.op = OP_PROBE;
         ST_CHECK: if (!status.taken_hit) cmd.op = OP_CLAIM;
         ST_TURN_WR: cmd.op = OP_TURN_WRITE;
         ST_FINISH: cmd.op = OP_FINISH;
         ST_RESP: if (status.rsp_free) cmd.op = OP_RESP;
         default: cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### rtl/mlv_dpath.sv
// ----------------------------------------------------------------------------
// mlv_dpath
// Tables, backend store, remainder unit, config and result registers.
// ----------------------------------------------------------------------------
module mlv_dpath #(
   parameter int TABLE_DEPTH  = mlv_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_BACKENDS = mlv_pkg::MAX_BACKENDS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mlv_pkg::mlv_req_type    req_data,
   input  logic                    csr_wr,
   input  logic                    csr_index,
   input  logic [15:0]             csr_wdata,
   input  mlv_pkg::mlv_cmd_type    cmd,
   output mlv_pkg::mlv_status_type status,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output mlv_pkg::mlv_rsp_type    rsp_data
);
   import mlv_pkg::*;

   localparam int IW  = $clog2(TABLE_DEPTH);
   localparam int MW  = IW + 1;
   localparam int BW  = $clog2(MAX_BACKENDS + 1);
   localparam int BIW = $clog2(MAX_BACKENDS);
   localparam int EW  = BW;
   localparam int WW  = MW + 2 * IW;

   // memories
   logic [EW-1:0] cur_mem   [TABLE_DEPTH];
   logic [EW-1:0] prev_mem  [TABLE_DEPTH];
   logic          taken_mem [TABLE_DEPTH];
   logic [WW-1:0] bk_mem    [MAX_BACKENDS];

   logic [EW-1:0] cur_rd_ff, prev_rd_ff;
   logic          taken_rd_ff;
   logic [WW-1:0] bk_rd_ff;

   mlv_req_type   req_ff;
   mlv_rsp_type   res_ff, res_in;
   mlv_rsp_type   rsp_data_ff;
   logic          rsp_valid_ff;
   logic [12:0]   tsize_ff;
   logic [15:0]   tmo_ff;
   logic [BW-1:0] count_ff, count_in;
   logic          pending_ff, pending_in;
   logic          live_ff, live_in;
   logic [15:0]   ticks_ff, ticks_in;
   logic [IW-1:0] off_ff, off_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic [IW-1:0] skip_ff, skip_in;
   logic [MW-1:0] next_ff, next_in;
   logic [IW-1:0] ppos_ff, ppos_in;
   logic [BIW-1:0] bi_ff, bi_in;
   logic [MW-1:0] filled_ff, filled_in;
   logic          claimed_ff, claimed_in;
   logic [IW-1:0] sw_ff, sw_in;
   logic          cp_en_ff;
   logic [IW-1:0] cp_addr_ff;

   logic [MW-1:0] m, m_less;
   logic [31:0]   mod_dvd;
   logic [MW-1:0] mod_div, mod_rem;
   logic          mod_done;
   logic [IW-1:0] lk_addr, cur_raddr;
   logic [MW-1:0] pos_sum;
   logic [15:0]   tick_val;
   logic [EW-1:0] c_ent, p_ent, c_m1, p_m1;

   // slot count in use, clamped to [2, TABLE_DEPTH]
   always_comb begin
      if ({19'b0, tsize_ff} > 32'(TABLE_DEPTH)) begin
         m = MW'(TABLE_DEPTH);
      end else if (tsize_ff < 13'd2) begin
         m = MW'(2);
      end else begin
         m = MW'(tsize_ff);
      end
      m_less = m - MW'(1);
   end

   always_comb begin
      mod_dvd = req_ff.backend_hash_a;
      mod_div = m;
      unique case (cmd.mod_src)
         MS_HASH_A: mod_dvd = req_ff.backend_hash_a;
         MS_HASH_B: begin
            mod_dvd = req_ff.backend_hash_b;
            mod_div = m_less;
         end
         MS_KEY: mod_dvd = req_ff.key_hash;
         MS_POS: mod_dvd = 32'(pos_ff);
         MS_SKIP: begin
            mod_dvd = 32'(skip_ff) + 32'(m) - 32'd2;
            mod_div = m_less;
         end
         default: mod_dvd = req_ff.backend_hash_a;
      endcase
   end

   mlv_mod #(.DW(MW)) u_mod (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.mod_go),
      .dividend (mod_dvd),
      .divisor  (mod_div),
      .done     (mod_done),
      .rem      (mod_rem)
   );

   assign lk_addr   = mod_rem[IW-1:0];
   assign cur_raddr = (cmd.op == OP_COPY_STEP) ? sw_ff : lk_addr;
   assign pos_sum   = {1'b0, pos_ff} + {1'b0, skip_ff};
   assign tick_val  = (ticks_ff == 16'hFFFF) ? 16'hFFFF : ticks_ff + 16'd1;
   assign c_ent     = cur_rd_ff;
   assign p_ent     = prev_rd_ff;
   assign c_m1      = c_ent - EW'(1);
   assign p_m1      = p_ent - EW'(1);

   always_comb begin
      res_in     = res_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      live_in    = live_ff;
      ticks_in   = ticks_ff;
      off_in     = off_ff;
      pos_in     = pos_ff;
      skip_in    = skip_ff;
      next_in    = next_ff;
      ppos_in    = ppos_ff;
      bi_in      = bi_ff;
      filled_in  = filled_ff;
      claimed_in = claimed_ff;
      sw_in      = sw_ff;
      unique case (cmd.op)
         OP_LATCH: res_in = '0;
         OP_LD_OVF: res_in.overflow = 1'b1;
         OP_LD_OFF: off_in = mod_rem[IW-1:0];
         OP_LD_SKIP: skip_in = IW'(mod_rem + MW'(1));
         OP_LD_WRITE: count_in = count_ff + BW'(1);
         OP_LK_CAPT: begin
            res_in.stable       = (p_ent == '0) || (c_ent == p_ent);
            res_in.curr_valid   = (c_ent != '0);
            res_in.curr_backend = (c_ent != '0) ? 6'(c_m1) : 6'd0;
            res_in.prev_valid   = (p_ent != '0);
            res_in.prev_backend = (p_ent != '0) ? 6'(p_m1) : 6'd0;
         end
         OP_TICK: begin
            if (pending_ff) begin
               if (tick_val >= tmo_ff) begin
                  res_in.merged = 1'b1;
                  pending_in    = 1'b0;
                  ticks_in      = '0;
               end else begin
                  ticks_in = tick_val;
               end
            end
         end
         OP_CLEAR: begin
            // both tables read as empty until the next build rewrites them
            pending_in = 1'b0;
            ticks_in   = '0;
            live_in    = 1'b0;
            count_in   = '0;
         end
         OP_COPY_STEP, OP_CLR_STEP: sw_in = sw_ff + IW'(1);
         OP_BI_ZERO: bi_in = '0;
         OP_BK_LATCH: begin
            pos_in  = bk_rd_ff[IW-1:0];
            skip_in = bk_rd_ff[2*IW-1:IW];
            next_in = bk_rd_ff[WW-1:2*IW];
         end
         OP_PR_POS: pos_in = mod_rem[IW-1:0];
         OP_PR_SKIP: skip_in = IW'(mod_rem + MW'(1));
         OP_PR_WRITE: bi_in = bi_ff + BIW'(1);
         OP_RUN_INIT: begin
            bi_in      = '0;
            filled_in  = '0;
            claimed_in = 1'b0;
         end
         OP_PROBE: begin
            ppos_in = pos_ff;
            next_in = next_ff + MW'(1);
            pos_in  = (pos_sum >= m) ? IW'(pos_sum - m) : pos_sum[IW-1:0];
         end
         OP_CLAIM: begin
            filled_in  = filled_ff + MW'(1);
            claimed_in = 1'b1;
         end
         OP_TURN_WRITE: begin
            if (status.last_bi) begin
               bi_in      = '0;
               claimed_in = 1'b0;
            end else begin
               bi_in = bi_ff + BIW'(1);
            end
         end
         OP_FINISH: begin
            count_in   = '0;
            live_in    = 1'b1;
            pending_in = 1'b1;
            ticks_in   = '0;
         end
         default: res_in = res_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff     <= TABLE_SIZE_RST;
         tmo_ff       <= MERGE_TIMEOUT_RST;
         count_ff     <= '0;
         pending_ff   <= 1'b0;
         live_ff      <= 1'b0;
         ticks_ff     <= '0;
         sw_ff        <= '0;
         cp_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bi_ff        <= '0;
         filled_ff    <= '0;
         claimed_ff   <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (csr_index)
               CSR_TABLE_SIZE:    tsize_ff <= csr_wdata[12:0];
               CSR_MERGE_TIMEOUT: tmo_ff   <= csr_wdata;
               default:           tmo_ff   <= tmo_ff;
            endcase
         end
         count_ff   <= count_in;
         pending_ff <= pending_in;
         live_ff    <= live_in;
         ticks_ff   <= ticks_in;
         sw_ff      <= sw_in;
         cp_en_ff   <= (cmd.op == OP_COPY_STEP);
         bi_ff      <= bi_in;
         filled_ff  <= filled_in;
         claimed_ff <= claimed_in;
         if (cmd.op == OP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LATCH) req_ff <= req_data;
      if (cmd.op == OP_RESP) rsp_data_ff <= res_ff;
      res_ff     <= res_in;
      off_ff     <= off_in;
      pos_ff     <= pos_in;
      skip_ff    <= skip_in;
      next_ff    <= next_in;
      ppos_ff    <= ppos_in;
      cp_addr_ff <= sw_ff;
   end

   // current table
   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLR_STEP) begin
         cur_mem[sw_ff] <= '0;
      end else if (cmd.op == OP_CLAIM) begin
         cur_mem[ppos_ff] <= EW'(bi_ff) + EW'(1);
      end
      cur_rd_ff <= cur_mem[cur_raddr];
   end

   // previous table, written in the cycle after the copy read
   always_ff @(posedge clock) begin
      if (cp_en_ff) begin
         prev_mem[cp_addr_ff] <= live_ff ? cur_rd_ff : '0;
      end
      prev_rd_ff <= prev_mem[lk_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_CLR_STEP) begin
         taken_mem[sw_ff] <= 1'b0;
      end else if (cmd.op == OP_CLAIM) begin
         taken_mem[ppos_ff] <= 1'b1;
      end
      taken_rd_ff <= taken_mem[pos_ff];
   end

   // per-backend word: next, skip, position
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LD_WRITE) begin
         bk_mem[count_ff[BIW-1:0]] <= {MW'(0), skip_ff, off_ff};
      end else if (cmd.op == OP_PR_WRITE) begin
         bk_mem[bi_ff] <= {MW'(0), skip_ff, pos_ff};
      end else if (cmd.op == OP_TURN_WRITE) begin
         bk_mem[bi_ff] <= {next_ff, skip_ff, pos_ff};
      end
      bk_rd_ff <= bk_mem[bi_ff];
   end

   always_comb begin
      status.req_kind   = mlv_req_kind_type'(req_ff.req_type);
      status.last       = req_ff.last_backend;
      status.live       = live_ff;
      status.pending    = pending_ff;
      status.tick_merge = (tick_val >= tmo_ff);
      status.ovf_full   = (count_ff >= BW'(MAX_BACKENDS));
      status.mod_done   = mod_done;
      status.sweep_last = &sw_ff;
      status.n_zero     = (count_ff == '0);
      status.last_bi    = (BW'(bi_ff) == count_ff - BW'(1));
      status.full       = (filled_ff == m);
      status.exhausted  = (next_ff >= m);
      status.taken_hit  = taken_rd_ff;
      status.claimed    = claimed_ff;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives load, lookup, tick and clear requests into the maglev table block
// with random idle and stall gaps, predicts every result beat from its own
// table model and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
import mlv_pkg::*;

class maglev_table_sb;
   localparam int DEPTH = 4096;
   localparam int NB    = 64;

   bit [6:0]    cur_tab[DEPTH];
   bit [6:0]    prev_tab[DEPTH];
   bit          taken[DEPTH];
   int unsigned bk_off[NB];
   int unsigned bk_skip[NB];
   int unsigned bk_next[NB];
   int unsigned bk_count;
   bit          merge_pend;
   int unsigned merge_cnt;
   bit          live;
   int unsigned size_reg;
   int unsigned timeout_reg;
   mlv_rsp_type expected_rsp_q[$];
   int          errors;

   function new();
      cur_tab     = '{default: 0};
      prev_tab    = '{default: 0};
      taken       = '{default: 0};
      bk_count    = 0;
      merge_pend  = 0;
      merge_cnt   = 0;
      live        = 0;
      size_reg    = TABLE_SIZE_RST;
      timeout_reg = MERGE_TIMEOUT_RST;
      errors      = 0;
   endfunction

   function void write_reg(logic idx, logic [15:0] d);
      if (idx == CSR_TABLE_SIZE) size_reg = d & 16'h1FFF;
      else timeout_reg = d;
   endfunction

   function int unsigned slots();
      if (size_reg < 2) return 2;
      if (size_reg > DEPTH) return DEPTH;
      return size_reg;
   endfunction

   function void build_table();
      int unsigned m, n, filled, pos;
      bit claimed, found;
      m = slots();
      n = bk_count;
      filled = 0;
      if (!merge_pend) begin
         if (live) prev_tab = cur_tab;
         else prev_tab = '{default: 0};
      end
      cur_tab = '{default: 0};
      taken   = '{default: 0};
      for (int i = 0; i < n; i++) begin
         bk_off[i]  = bk_off[i] % m;
         bk_skip[i] = ((bk_skip[i] + m - 2) % (m - 1)) + 1;
         bk_next[i] = 0;
      end
      while (filled < m && n > 0) begin
         claimed = 0;
         for (int i = 0; i < n && filled < m; i++) begin
            found = 0;
            pos = 0;
            while (bk_next[i] < m) begin
               pos = (bk_off[i] + bk_next[i] * bk_skip[i]) % m;
               bk_next[i]++;
               if (!taken[pos]) begin
                  found = 1;
                  break;
               end
            end
            if (found) begin
               taken[pos]   = 1;
               cur_tab[pos] = i + 1;
               filled++;
               claimed = 1;
            end
         end
         if (!claimed) break;
      end
      bk_count   = 0;
      live       = 1;
      merge_pend = 1;
      merge_cnt  = 0;
   endfunction

   function void note_request(mlv_req_type r);
      mlv_rsp_type e;
      int unsigned m, idx;
      bit [6:0] c, p;
      e = '0;
      m = slots();
      case (r.req_type)
         REQ_LOAD: begin
            if (bk_count >= NB) begin
               e.overflow = 1;
            end else begin
               bk_off[bk_count]  = r.backend_hash_a % m;
               bk_skip[bk_count] = (r.backend_hash_b % (m - 1)) + 1;
               bk_count++;
            end
            if (r.last_backend) build_table();
         end
         REQ_LOOKUP: begin
            if (live) begin
               idx = r.key_hash % m;
               c = cur_tab[idx];
               p = prev_tab[idx];
               e.stable = (p == 0 || c == p);
               if (c != 0) begin
                  e.curr_valid   = 1;
                  e.curr_backend = c - 1;
               end
               if (p != 0) begin
                  e.prev_valid   = 1;
                  e.prev_backend = p - 1;
               end
            end
         end
         REQ_TICK: begin
            if (merge_pend) begin
               if (merge_cnt < 16'hFFFF) merge_cnt++;
               if (merge_cnt >= timeout_reg) begin
                  prev_tab   = cur_tab;
                  merge_pend = 0;
                  merge_cnt  = 0;
                  e.merged   = 1;
               end
            end
         end
         default: begin
            cur_tab    = '{default: 0};
            prev_tab   = '{default: 0};
            merge_pend = 0;
            merge_cnt  = 0;
            live       = 0;
            bk_count   = 0;
         end
      endcase
      expected_rsp_q.push_back(e);
   endfunction

   function void cmp(string fname, int unsigned e, int unsigned a);
      if (e != a) begin
         $error("%s: expected %0d, actual %0d", fname, e, a);
         errors++;
      end
   endfunction

   function void check_result(mlv_rsp_type a);
      mlv_rsp_type e;
      if (expected_rsp_q.size() == 0) begin
         $error("result beat with no request outstanding");
         errors++;
         return;
      end
      e = expected_rsp_q.pop_front();
      cmp("stable", e.stable, a.stable);
      cmp("curr_valid", e.curr_valid, a.curr_valid);
      cmp("curr_backend", e.curr_backend, a.curr_backend);
      cmp("prev_valid", e.prev_valid, a.prev_valid);
      cmp("prev_backend", e.prev_backend, a.prev_backend);
      cmp("merged", e.merged, a.merged);
      cmp("overflow", e.overflow, a.overflow);
   endfunction
endclass

module testbench;
   localparam int CYCLE_LIMIT = 12_000_000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   mlv_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   mlv_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_wdata;

   maglev_table_build_and_lookup u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   maglev_table_sb sb = new();
   int unsigned    cycles = 0;
   bit             req_burst = 0;
   bit             rsp_burst = 0;
   int             sent = 0;

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function mlv_req_type rand_req(mlv_req_kind_type kind);
      mlv_req_type r;
      r.req_type       = kind;
      r.backend_hash_a = $urandom;
      r.backend_hash_b = $urandom;
      r.last_backend   = $urandom_range(0, 1);
      r.key_hash       = $urandom;
      return r;
   endfunction

   task send_req(mlv_req_type r);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   task send_kind(mlv_req_kind_type kind);
      send_req(rand_req(kind));
   endtask

   task send_load(logic [31:0] ha, logic [31:0] hb, logic last);
      mlv_req_type r;
      r = rand_req(REQ_LOAD);
      r.backend_hash_a = ha;
      r.backend_hash_b = hb;
      r.last_backend   = last;
      send_req(r);
   endtask

   task send_lookup(logic [31:0] key);
      mlv_req_type r;
      r = rand_req(REQ_LOOKUP);
      r.key_hash = key;
      send_req(r);
   endtask

   // wait for every result, then let the sequencer settle before a csr write
   task drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp_q.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task csr_write(logic idx, logic [15:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task backend_list(int k, bit finish);
      for (int i = 0; i < k; i++)
         send_load($urandom, $urandom, finish && (i == k - 1));
   endtask

   task random_phase(int count, int max_list);
      int r, n, stop;
      stop = sent + count;
      while (sent < stop) begin
         if ($urandom_range(0, 19) == 0) req_burst = ~req_burst;
         r = $urandom_range(0, 99);
         if (r < 45) begin
            n = $urandom_range(1, 6);
            repeat (n) send_kind(REQ_LOOKUP);
         end else if (r < 65) begin
            n = $urandom_range(1, 4);
            repeat (n) send_kind(REQ_TICK);
         end else if (r < 88) begin
            if ($urandom_range(0, 29) == 0) n = 66;
            else n = $urandom_range(1, max_list);
            backend_list(n, $urandom_range(0, 4) != 0);
         end else if (r < 93) begin
            send_kind(REQ_CLEAR);
         end else begin
            send_req(rand_req(mlv_req_kind_type'($urandom_range(0, 3))));
         end
      end
   endtask

   // result side: random stall before each beat, with stall-free stretches
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_burst = ~rsp_burst;
         n = rsp_burst ? 0 : $urandom_range(0, 8);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
         @(negedge clock);
      end
   end

   initial begin
      int unsigned sizes[10] = '{3, 5, 7, 12, 13, 16, 31, 61, 97, 101};
      int unsigned touts[6]  = '{0, 1, 2, 3, 5, 10};
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_TABLE_SIZE;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings
      send_lookup(32'h0);
      send_kind(REQ_TICK);
      send_kind(REQ_CLEAR);
      send_load(32'h0, 32'h0, 1'b0);
      send_load(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_load($urandom, $urandom, 1'b1);
      send_lookup(32'h0);
      send_lookup(32'hFFFF_FFFF);
      repeat (2) send_kind(REQ_LOOKUP);
      repeat (10) send_kind(REQ_TICK);
      send_kind(REQ_LOOKUP);
      send_kind(REQ_CLEAR);
      send_lookup(32'h0);
      drain();

      // size below range, merge on first tick
      csr_write(CSR_TABLE_SIZE, 16'h0000);
      csr_write(CSR_MERGE_TIMEOUT, 16'h0000);
      backend_list(2, 1);
      send_lookup(32'h0);
      send_lookup(32'h1);
      send_kind(REQ_TICK);
      send_kind(REQ_TICK);
      backend_list(3, 0);
      drain();

      // size above range; skips 2 and 4 leave slots empty
      csr_write(CSR_TABLE_SIZE, 16'hFFFF);
      csr_write(CSR_MERGE_TIMEOUT, 16'hFFFF);
      send_load(32'h0, 32'h1, 1'b0);
      send_load(32'h1, 32'h3, 1'b1);
      send_lookup(32'h0);
      send_lookup(32'h3);
      send_lookup(32'hFFFF_FFFF);
      send_kind(REQ_TICK);
      drain();

      while (sent < 1200) begin
         csr_write(CSR_TABLE_SIZE, sizes[$urandom_range(0, 9)]);
         if ($urandom_range(0, 5) == 0) csr_write(CSR_MERGE_TIMEOUT, 16'hFFFF);
         else csr_write(CSR_MERGE_TIMEOUT, touts[$urandom_range(0, 5)]);
         random_phase($urandom_range(80, 120), 8);
         drain();
      end

      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.expected_rsp_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

### maglev_table_build_and_lookup.f
rtl/mlv_pkg.sv
rtl/mlv_mod.sv
rtl/mlv_ctrl.sv
rtl/mlv_dpath.sv
rtl/maglev_table_build_and_lookup.sv
dv/testbench.sv
